// File: hdl/bgs_pkg.sv
// package: shared constants, widths and the job record for the burgers step block
`timescale 1ns / 1ps
`default_nettype none

package bgs_pkg;

    // grid and number format
    localparam int MAX_CELLS = 4096;
    localparam int FRAC_BITS = 16;
    localparam int CELL_W    = 32;
    localparam int IDX_W     = $clog2(MAX_CELLS + 1);
    localparam int RATIO_W   = 32;

    // configuration register indexes
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVECT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE = CFG_IDX_W'(1);
    localparam logic [RATIO_W-1:0]   CONVECT_RESET = RATIO_W'(6554);
    localparam logic [RATIO_W-1:0]   DIFFUSE_RESET = RATIO_W'(0);

    // datapath widths
    localparam int MUL_W    = CELL_W + 1;            // signed multiplier operand
    localparam int PROD_W   = 2 * CELL_W;            // kept product bits
    localparam int FLUX_W   = 2 * CELL_W - 2 - FRAC_BITS;
    localparam int DFL_W    = FLUX_W + 1;            // flux difference, signed
    localparam int DFL_LO   = 24;
    localparam int DFL_HI_W = DFL_W - DFL_LO;
    localparam int LAP_W    = CELL_W + 3;            // second difference, signed
    localparam int LAP_LO   = 18;
    localparam int LAP_HI_W = LAP_W - LAP_LO;
    localparam int ACC_W    = DFL_W + 34;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // one cell update for the back end
    typedef struct packed {
        logic signed [CELL_W-1:0] um;
        logic signed [CELL_W-1:0] ui;
        logic signed [CELL_W-1:0] up;
        logic [IDX_W-1:0]         idx;
        logic                     dup;
        logic [IDX_W-1:0]         dup_idx;
    } t_job;

endpackage

`default_nettype wire

// File: hdl/bgs_if.sv
// interfaces: cell input, configuration write and result channels
`timescale 1ns / 1ps
`default_nettype none

interface bgs_in_if;
    import bgs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [CELL_W-1:0] cell_value;
    logic                     last_cell;
    modport source (output valid, cell_value, last_cell, input ready);
    modport sink   (input valid, cell_value, last_cell, output ready);
endinterface

interface bgs_cfg_if;
    import bgs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [RATIO_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface bgs_out_if;
    import bgs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         cell_index;
    logic signed [CELL_W-1:0] new_value;
    logic                     saturated;
    logic                     last_result;
    modport source (output valid, cell_index, new_value, saturated, last_result,
                    input ready);
    modport sink   (input valid, cell_index, new_value, saturated, last_result,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/bgs_front.sv
// front end: takes cells, keeps the grid window and issues cell update jobs
`timescale 1ns / 1ps
`default_nettype none

module bgs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bgs_in_if.sink        i_cell,
    input  logic          i_full,
    output logic          o_push,
    output bgs_pkg::t_job o_job
);
    import bgs_pkg::*;

    localparam logic [IDX_W-1:0] K_LAST = IDX_W'(MAX_CELLS - 1);

    logic [IDX_W-1:0]         r_seen;
    logic [IDX_W-1:0]         r_k;
    logic [2:0]               r_pend;
    logic signed [CELL_W-1:0] r_first;
    logic signed [CELL_W-1:0] r_second;
    logic signed [CELL_W-1:0] r_w0;
    logic signed [CELL_W-1:0] r_w1;
    logic signed [CELL_W-1:0] r_w2;

    logic [IDX_W-1:0] k_in;
    logic             last_in;
    logic [2:0]       push_bit;
    logic [2:0]       pend_after;
    logic             accept;

    // cell number of the incoming item, overlong grids close at the last slot
    assign k_in    = (r_seen >= K_LAST) ? K_LAST : r_seen;
    assign last_in = i_cell.last_cell | (k_in == K_LAST);

    // pending jobs go out oldest first: interior cell, last cell, cell zero
    always_comb begin
        push_bit = 3'b000;
        if (r_pend[0]) begin
            push_bit = 3'b001;
        end else if (r_pend[1]) begin
            push_bit = 3'b010;
        end else if (r_pend[2]) begin
            push_bit = 3'b100;
        end
    end

    assign o_push       = (|r_pend) && !i_full;
    assign pend_after   = o_push ? (r_pend & ~push_bit) : r_pend;
    assign i_cell.ready = (pend_after == 3'b000);
    assign accept       = i_cell.valid && i_cell.ready;

    // job fields from the window as it stands after the item was taken
    always_comb begin
        o_job.dup     = 1'b0;
        o_job.dup_idx = r_k + IDX_W'(1);
        o_job.um      = r_w0;
        o_job.ui      = r_w1;
        o_job.up      = r_w2;
        o_job.idx     = r_k - IDX_W'(1);
        if (push_bit[1]) begin
            o_job.um  = r_w1;
            o_job.ui  = r_w2;
            o_job.up  = r_first;
            o_job.idx = r_k;
        end else if (push_bit[2]) begin
            o_job.um  = r_w2;
            o_job.ui  = r_first;
            o_job.up  = (r_k != '0) ? r_second : r_first;
            o_job.idx = '0;
            o_job.dup = 1'b1;
        end
    end

    // window, counter and pending job flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= '0;
            r_k      <= '0;
            r_pend   <= 3'b000;
            r_first  <= '0;
            r_second <= '0;
            r_w0     <= '0;
            r_w1     <= '0;
            r_w2     <= '0;
        end else begin
            r_pend <= pend_after;
            if (accept) begin
                r_w0   <= r_w1;
                r_w1   <= r_w2;
                r_w2   <= i_cell.cell_value;
                r_k    <= k_in;
                r_seen <= last_in ? '0 : k_in + IDX_W'(1);
                r_pend <= {last_in, last_in && (k_in != '0), k_in >= IDX_W'(2)};
                if (k_in == '0) begin
                    r_first <= i_cell.cell_value;
                end
                if (k_in == IDX_W'(1)) begin
                    r_second <= i_cell.cell_value;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/bgs_queue.sv
// job queue: short fifo between the front end and the back end
`timescale 1ns / 1ps
`default_nettype none

module bgs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bgs_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output bgs_pkg::t_job o_job,
    output logic          o_empty
);
    import bgs_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/bgs_back.sv
// back end: riemann fluxes and cell update on one shared multiplier, result register
`timescale 1ns / 1ps
`default_nettype none

module bgs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  bgs_pkg::t_job               i_job,
    output logic                        o_pop,
    input  logic [bgs_pkg::RATIO_W-1:0] i_convect,
    input  logic [bgs_pkg::RATIO_W-1:0] i_diffuse,
    bgs_out_if.source                   o_result
);
    import bgs_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQ_L   = 4'd1;
    localparam logic [3:0] ST_SQ_R   = 4'd2;
    localparam logic [3:0] ST_PREP   = 4'd3;
    localparam logic [3:0] ST_MUL_CL = 4'd4;
    localparam logic [3:0] ST_MUL_CH = 4'd5;
    localparam logic [3:0] ST_MUL_DL = 4'd6;
    localparam logic [3:0] ST_MUL_DH = 4'd7;
    localparam logic [3:0] ST_ADD    = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;
    localparam logic [3:0] ST_DUP    = 4'd10;

    logic [3:0]               r_state;
    t_job                     r_job;
    logic signed [PROD_W-1:0] r_prod;
    logic [FLUX_W-1:0]        r_fl;
    logic signed [DFL_W-1:0]  r_dfl;
    logic signed [LAP_W-1:0]  r_lap;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_ov;
    logic [IDX_W-1:0]         r_out_idx;
    logic signed [CELL_W-1:0] r_out_val;
    logic                     r_out_sat;
    logic                     r_out_last;

    logic signed [CELL_W-1:0]  ul;
    logic signed [CELL_W-1:0]  ur;
    logic signed [CELL_W:0]    lr_sum;
    logic signed [CELL_W-1:0]  pick;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic [FLUX_W-1:0]         prod_flux;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   add_term;
    logic signed [ACC_W-1:0]   acc_init;
    logic signed [LAP_W-1:0]   lap;
    logic [ACC_W-FRAC_BITS-CELL_W:0] acc_top;
    logic                      fits;
    logic signed [CELL_W-1:0]  sat_val;
    logic                      slot_free;
    logic                      out_load;

    // riemann flux: pick the state whose half square is the flux, or zero in the sonic fan
    assign ul     = (r_state == ST_SQ_L) ? r_job.um : r_job.ui;
    assign ur     = (r_state == ST_SQ_L) ? r_job.ui : r_job.up;
    assign lr_sum = {ul[CELL_W-1], ul} + {ur[CELL_W-1], ur};
    always_comb begin
        if (ul > ur) begin
            pick = (lr_sum > 0) ? ul : ur;
        end else if (!ul[CELL_W-1]) begin
            pick = ul;
        end else if (ur[CELL_W-1] || (ur == '0)) begin
            pick = ur;
        end else begin
            pick = '0;
        end
    end

    // shared multiplier: squares, then ratio times low and high parts
    always_comb begin
        case (r_state)
            ST_MUL_CL: begin
                mul_a = {1'b0, i_convect};
                mul_b = {{(MUL_W - DFL_LO){1'b0}}, r_dfl[DFL_LO-1:0]};
            end
            ST_MUL_CH: begin
                mul_a = {1'b0, i_convect};
                mul_b = {{(MUL_W - DFL_HI_W){r_dfl[DFL_W-1]}}, r_dfl[DFL_W-1:DFL_LO]};
            end
            ST_MUL_DL: begin
                mul_a = {1'b0, i_diffuse};
                mul_b = {{(MUL_W - LAP_LO){1'b0}}, r_lap[LAP_LO-1:0]};
            end
            ST_MUL_DH: begin
                mul_a = {1'b0, i_diffuse};
                mul_b = {{(MUL_W - LAP_HI_W){r_lap[LAP_W-1]}}, r_lap[LAP_W-1:LAP_LO]};
            end
            default: begin
                mul_a = {pick[CELL_W-1], pick};
                mul_b = {pick[CELL_W-1], pick};
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // half square is the product shifted by one more than the fraction bits
    assign prod_flux = r_prod[FLUX_W+FRAC_BITS:FRAC_BITS+1];
    assign prod_ext  = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // partial product alignment for the accumulator
    always_comb begin
        case (r_state)
            ST_MUL_DL: add_term = prod_ext <<< DFL_LO;
            ST_ADD:    add_term = prod_ext <<< LAP_LO;
            default:   add_term = prod_ext;
        endcase
    end

    // cell value in accumulator scale plus the rounding half
    assign acc_init = ({{(ACC_W - CELL_W){r_job.ui[CELL_W-1]}}, r_job.ui} <<< FRAC_BITS)
                    + (ACC_W'(1) <<< (FRAC_BITS - 1));

    // second difference up - 2 ui + um
    assign lap = {{(LAP_W - CELL_W){r_job.up[CELL_W-1]}}, r_job.up}
               - ({{(LAP_W - CELL_W){r_job.ui[CELL_W-1]}}, r_job.ui} <<< 1)
               + {{(LAP_W - CELL_W){r_job.um[CELL_W-1]}}, r_job.um};

    // drop the fraction and clip to the cell range
    assign acc_top = r_acc[ACC_W-1:FRAC_BITS+CELL_W-1];
    assign fits    = (&acc_top) || !(|acc_top);
    assign sat_val = r_acc[ACC_W-1] ? {1'b1, {(CELL_W - 1){1'b0}}}
                                    : {1'b0, {(CELL_W - 1){1'b1}}};

    assign slot_free = !r_ov || o_result.ready;
    assign out_load  = slot_free && ((r_state == ST_OUT) || (r_state == ST_DUP));
    assign o_pop     = (r_state == ST_IDLE) && !i_empty;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE:   if (!i_empty) r_state <= ST_SQ_L;
                ST_SQ_L:   r_state <= ST_SQ_R;
                ST_SQ_R:   r_state <= ST_PREP;
                ST_PREP:   r_state <= ST_MUL_CL;
                ST_MUL_CL: r_state <= ST_MUL_CH;
                ST_MUL_CH: r_state <= ST_MUL_DL;
                ST_MUL_DL: r_state <= ST_MUL_DH;
                ST_MUL_DH: r_state <= ST_ADD;
                ST_ADD:    r_state <= ST_OUT;
                ST_OUT: begin
                    if (slot_free) begin
                        r_state <= r_job.dup ? ST_DUP : ST_IDLE;
                    end
                end
                ST_DUP:    if (slot_free) r_state <= ST_IDLE;
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        case (r_state)
            ST_SQ_L: begin
                r_prod <= mul_p[PROD_W-1:0];
            end
            ST_SQ_R: begin
                r_fl   <= prod_flux;
                r_prod <= mul_p[PROD_W-1:0];
            end
            ST_PREP: begin
                r_dfl <= $signed({1'b0, r_fl}) - $signed({1'b0, prod_flux});
                r_lap <= lap;
                r_acc <= acc_init;
            end
            ST_MUL_CL: begin
                r_prod <= mul_p[PROD_W-1:0];
            end
            ST_MUL_CH, ST_MUL_DL, ST_MUL_DH: begin
                r_acc  <= r_acc + add_term;
                r_prod <= mul_p[PROD_W-1:0];
            end
            ST_ADD: begin
                r_acc <= r_acc + add_term;
            end
            default: begin
            end
        endcase
    end

    // result register, the duplicate point repeats cell zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx  <= (r_state == ST_DUP) ? r_job.dup_idx : r_job.idx;
            r_out_val  <= fits ? r_acc[FRAC_BITS+CELL_W-1:FRAC_BITS] : sat_val;
            r_out_sat  <= !fits;
            r_out_last <= (r_state == ST_DUP);
        end
    end

    assign o_result.valid       = r_ov;
    assign o_result.cell_index  = r_out_idx;
    assign o_result.new_value   = r_out_val;
    assign o_result.saturated   = r_out_sat;
    assign o_result.last_result = r_out_last;

endmodule

`default_nettype wire

// File: hdl/burgers_godunov_step_top.sv
// top level: configuration registers and the front, queue and back end
`timescale 1ns / 1ps
`default_nettype none

// One time step of the first-order Godunov scheme for viscous 1D Burgers on a
// periodic grid, signed Q16.16. Cells stream in on i_cell, last_cell marking
// the final physical cell; cell i comes out of o_result once cell i+1 has
// arrived, and after the last cell come that cell, cell 0 and the periodic
// duplicate point (last_result high, same value as cell 0). The front end
// takes one cell per cycle into a four-entry job queue while the queue
// has room; the back end runs every cell update through one shared 33x33
// multiplier in order: two flux squares, prep, four ratio partial products,
// accumulate and output, then fetches the next job, taking no new job before
// the last is through; the grid's closing cell costs three updates and the
// duplicate. Registers on i_cfg: index 0 is dt/dx, index 1 is nu*dt/dx^2,
// both unsigned Q16.16; write them only while the block is idle.

module burgers_godunov_step_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bgs_in_if.sink    i_cell,
    bgs_cfg_if.sink   i_cfg,
    bgs_out_if.source o_result
);
    import bgs_pkg::*;

    logic [RATIO_W-1:0] r_convect;
    logic [RATIO_W-1:0] r_diffuse;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_job push_job;
    t_job head_job;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_convect <= CONVECT_RESET;
            r_diffuse <= DIFFUSE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CONVECT: r_convect <= i_cfg.data;
                CFG_DIFFUSE: r_diffuse <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // cell window and job issue
    bgs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (i_cell),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (push_job)
    );

    // job queue
    bgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    // flux and update arithmetic
    bgs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_job     (head_job),
        .o_pop     (q_pop),
        .i_convect (r_convect),
        .i_diffuse (r_diffuse),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// testbench for the burgers godunov step block: directed and random grids, self-checking
`timescale 1ns / 1ps

module tb_top;
    import bgs_pkg::*;

    typedef logic signed [127:0]      wide_t;
    typedef logic signed [CELL_W-1:0] cell_t;

    // one updated cell as it leaves the block
    typedef struct {
        logic [IDX_W-1:0] idx;
        cell_t            val;
        logic             sat;
        logic             last;
    } update_t;

    // tracks the grid window and predicts every updated cell
    class burgers_step_scoreboard;
        logic [RATIO_W-1:0] convect;
        logic [RATIO_W-1:0] diffuse;
        cell_t              cell0_u;
        cell_t              cell1_u;
        cell_t              prev_u;
        cell_t              curr_u;
        logic signed [63:0] flux_left;
        int unsigned        cells_in_grid;
        update_t            updates_due[$];
        int                 errors;
        int                 cells_total;
        int                 grids_total;
        int                 updates_checked;
        int                 sat_seen;

        function new();
            convect         = CONVECT_RESET;
            diffuse         = DIFFUSE_RESET;
            cell0_u         = '0;
            cell1_u         = '0;
            prev_u          = '0;
            curr_u          = '0;
            flux_left       = '0;
            cells_in_grid   = 0;
            errors          = 0;
            cells_total     = 0;
            grids_total     = 0;
            updates_checked = 0;
            sat_seen        = 0;
        endfunction

        function int pending();
            return updates_due.size();
        endfunction

        function void write_ratio(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] val);
            case (idx)
                CFG_CONVECT: convect = val;
                CFG_DIFFUSE: diffuse = val;
                default: ;
            endcase
        endfunction

        // u*u/2 in fixed point, truncated
        function logic signed [63:0] half_square(cell_t u);
            logic signed [63:0] w;
            logic [63:0]        sq;
            w  = u;
            sq = w * w;
            return sq >> (FRAC_BITS + 1);
        endfunction

        // exact riemann flux: shock, rarefaction and sonic fan
        function logic signed [63:0] godunov_flux(cell_t ul, cell_t ur);
            logic signed [32:0] sum;
            sum = ul + ur;
            if (ul > ur) return (sum > 0) ? half_square(ul) : half_square(ur);
            if (ul >= 0) return half_square(ul);
            if (ur <= 0) return half_square(ur);
            return '0;
        endfunction

        // conservative update plus diffusion, rounded half up, then clipped
        function update_t cell_update(cell_t um, cell_t ui, cell_t up,
                                      logic signed [63:0] fl, logic signed [63:0] fr);
            wide_t   acc;
            wide_t   dflux;
            wide_t   lap;
            wide_t   cw;
            wide_t   dw;
            update_t r;
            cw    = $signed({96'b0, convect});
            dw    = $signed({96'b0, diffuse});
            dflux = wide_t'(fl) - wide_t'(fr);
            lap   = wide_t'(up) + wide_t'(um) - (wide_t'(ui) <<< 1);
            acc   = (wide_t'(ui) <<< FRAC_BITS) + cw * dflux + dw * lap
                    + (wide_t'(1) <<< (FRAC_BITS - 1));
            acc   = acc >>> FRAC_BITS;
            r.idx  = '0;
            r.last = 1'b0;
            if (acc > wide_t'(32'sh7FFF_FFFF)) begin
                r.val = 32'sh7FFF_FFFF;
                r.sat = 1'b1;
            end else if (acc < wide_t'($signed(32'h8000_0000))) begin
                r.val = $signed(32'h8000_0000);
                r.sat = 1'b1;
            end else begin
                r.val = acc[CELL_W-1:0];
                r.sat = 1'b0;
            end
            return r;
        endfunction

        function void queue_update(update_t r, int unsigned idx, logic last);
            r.idx  = IDX_W'(idx);
            r.last = last;
            updates_due.push_back(r);
        endfunction

        // an accepted input cell
        function void accept_cell(cell_t u, logic last_cell);
            int unsigned        k;
            logic               closing;
            logic signed [63:0] fr;
            logic signed [63:0] fwrap;
            cell_t              u1;
            update_t            r;
            k       = cells_in_grid;
            closing = last_cell;
            cells_total++;
            // an overlong grid closes at the top index regardless of the flag
            if (k >= MAX_CELLS - 1) begin
                k       = MAX_CELLS - 1;
                closing = 1'b1;
            end
            if (k == 0) begin
                cell0_u = u;
            end else begin
                fr = godunov_flux(curr_u, u);
                if (k >= 2)
                    queue_update(cell_update(prev_u, curr_u, u, flux_left, fr), k - 1, 1'b0);
                else
                    cell1_u = u;
                flux_left = fr;
            end
            prev_u = curr_u;
            curr_u = u;
            if (!closing) begin
                cells_in_grid = k + 1;
                return;
            end
            // wrap around: last cell, cell 0, then the duplicate of cell 0
            fwrap = godunov_flux(u, cell0_u);
            u1    = (k >= 1) ? cell1_u : cell0_u;
            if (k >= 1)
                queue_update(cell_update(prev_u, u, cell0_u, flux_left, fwrap), k, 1'b0);
            r = cell_update(u, cell0_u, u1, fwrap, godunov_flux(cell0_u, u1));
            queue_update(r, 0, 1'b0);
            queue_update(r, k + 1, 1'b1);
            cells_in_grid = 0;
            grids_total++;
        endfunction

        // an accepted result against the oldest prediction
        function void check_update(update_t got);
            update_t want;
            if (updates_due.size() == 0) begin
                $error("unexpected result: cell_index %0d new_value %0d", got.idx, got.val);
                errors++;
                return;
            end
            want = updates_due.pop_front();
            updates_checked++;
            if (got.sat) sat_seen++;
            if (got.idx !== want.idx) begin
                $error("cell_index: expected %0d, actual %0d", want.idx, got.idx);
                errors++;
            end
            if (got.val !== want.val) begin
                $error("new_value: expected %0d, actual %0d", want.val, got.val);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $error("saturated: expected %0b, actual %0b", want.sat, got.sat);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_result: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_PCT   = 27;
    localparam int SETTLE_CYC = 40;
    localparam int TAIL_CYC   = 50;
    localparam int STALL_MAX  = 2000;

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    bit   pause_mid;
    int   stall_cycles;

    cell_t grid_q[$];

    burgers_step_scoreboard sb;

    bgs_in_if  cell_if ();
    bgs_cfg_if cfg_if ();
    bgs_out_if res_if ();

    burgers_godunov_step_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (cell_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side back-pressure
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        update_t got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.idx  = res_if.cell_index;
            got.val  = res_if.new_value;
            got.sat  = res_if.saturated;
            got.last = res_if.last_result;
            sb.check_update(got);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (cell_if.valid && cell_if.ready) || (cfg_if.valid && cfg_if.ready)
            || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("tb_top: no handshake for %0d cycles, %0d results outstanding",
                     STALL_MAX, sb.pending());
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // send one cell item, with random gaps ahead of it
    task automatic push_cell(input cell_t u, input logic last_cell);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            cell_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.cell_value <= u;
        cell_if.last_cell  <= last_cell;
        do @(posedge i_clk); while (!cell_if.ready);
        sb.accept_cell(u, last_cell);
    endtask

    // stop sending until every predicted result is out
    task automatic drain();
        cell_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // send grid_q as one grid, flag on the final cell
    task automatic push_grid();
        for (int i = 0; i < grid_q.size(); i++) begin
            if (pause_mid && grid_q.size() >= 3 && i == grid_q.size() / 2) begin
                drain();
                pause_mid = 1'b0;
            end
            push_cell(grid_q[i], i == grid_q.size() - 1);
        end
    endtask

    // write both ratios once the block has gone quiet
    task automatic program_ratios(input logic [RATIO_W-1:0] c, input logic [RATIO_W-1:0] d);
        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_CONVECT;
        cfg_if.data  <= c;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_ratio(CFG_CONVECT, c);
        cfg_if.index <= CFG_DIFFUSE;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_ratio(CFG_DIFFUSE, d);
        cfg_if.valid <= 1'b0;
    endtask

    // mostly moderate values, some full range and some extremes
    function automatic cell_t rand_cell();
        int pick;
        pick = $urandom_range(9);
        if (pick < 2) return $urandom;
        if (pick == 2) begin
            case ($urandom_range(4))
                0: return 32'sh7FFF_FFFF;
                1: return $signed(32'h8000_0000);
                2: return 32'sh0000_0001;
                3: return -32'sh0000_0001;
                default: return '0;
            endcase
        end
        return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    // random grids of mostly short length until the item budget is spent
    task automatic random_grids(input int budget);
        int sent;
        int n;
        sent = 0;
        while (sent < budget) begin
            n = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            grid_q.delete();
            for (int i = 0; i < n; i++) grid_q.push_back(rand_cell());
            push_grid();
            sent += n;
        end
    endtask

    // stimulus
    initial begin
        i_rst_n            = 1'b0;
        calm               = 1'b0;
        pause_mid          = 1'b0;
        stall_cycles       = 0;
        cell_if.valid      = 1'b0;
        cell_if.cell_value = '0;
        cell_if.last_cell  = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_CONVECT;
        cfg_if.data        = '0;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset ratios: single cell grid, two cell grid, all flux cases
        grid_q = '{32'sh7FFF_FFFF};
        push_grid();
        grid_q = '{$signed(32'h8000_0000), 32'sh7FFF_FFFF};
        push_grid();
        // shock left, rarefaction, sonic fan, right-moving, shock right
        grid_q = '{32'sh0001_0000, 32'shFFFE_0000, 32'shFFFF_0000,
                   32'sh0000_8000, 32'sh0002_0000, 32'sh0000_0000};
        push_grid();

        // full scale ratios drive saturation both ways
        program_ratios('1, '1);
        grid_q = '{32'sh7FFF_FFFF, $signed(32'h8000_0000),
                   32'sh7FFF_FFFF, $signed(32'h8000_0000)};
        push_grid();

        // zero ratios leave the cells untouched
        program_ratios('0, '0);
        grid_q = '{$signed(32'h8000_0000), 32'sh0000_0000, 32'sh0000_0001};
        push_grid();

        program_ratios(32'd6554, 32'h0000_2000);
        grid_q = '{32'sh0001_0000, 32'shFFFE_0000, 32'shFFFF_0000,
                   32'sh0000_8000, 32'sh0002_0000, 32'sh0000_0000};
        push_grid();

        // random grids under several ratio settings
        program_ratios(32'd6554, $urandom_range(0, 32'h4000));
        calm = 1'b1;
        random_grids(18);
        calm = 1'b0;

        program_ratios($urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h8000));
        pause_mid = 1'b1;
        random_grids(18);

        program_ratios($urandom, $urandom);
        random_grids(18);

        program_ratios($urandom_range(0, 32'h0001_0000), '0);
        random_grids(18);

        drain();
        repeat (TAIL_CYC) @(posedge i_clk);
        $display("tb_top: %0d cells in %0d grids, %0d results checked, %0d saturated",
                 sb.cells_total, sb.grids_total, sb.updates_checked, sb.sat_seen);
        $display("tb_top: ratios from zero to full scale, grids of 1 to 12 cells");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
